// ----- rtl/core/base64_stream_encoder_assert.svh -----
// Assertion macros for the base64 stream encoder.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define B64E_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("base64 encoder check failed");

// next-cycle implication
`define B64E_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("base64 encoder check failed");

`endif

// ----- rtl/core/b64e_pkg.sv -----
`timescale 1ns / 1ps
package b64e_pkg;

	localparam logic [6:0] PAD_CHAR  = 7'h3D;
	localparam logic [1:0] CHAR_LAST = 2'd3;

	// one group of up to three bytes; nbytes is 1..3
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] nbytes;
		logic       last;
	} group_t;

	// standard alphabet lookup
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		unique case (v) inside
			[6'd0:6'd25]:  c = 7'(v) + 7'd65;
			[6'd26:6'd51]: c = 7'(v) + 7'd71;
			[6'd52:6'd61]: c = 7'(v) - 7'd4;
			6'd62:         c = 7'h2B;
			default:       c = 7'h2F;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/b64e_front.sv -----
`timescale 1ns / 1ps
module b64e_front import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	input  logic       grp_full,
	output logic       full,
	output logic       grp_push,
	output group_t     grp
);

	logic [7:0] held_q [2];
	logic [1:0] cnt_q;
	logic       acc;
	logic       closes;

	assign full   = grp_full;
	assign acc    = push & ~grp_full;
	// a group closes on the third byte or on the end flag
	assign closes = (cnt_q == 2'd2) | end_of_message;
	assign grp_push = acc & closes;

	always_comb begin
		grp.b0     = (cnt_q != 2'd0) ? held_q[0] : data_byte;
		grp.b1     = (cnt_q == 2'd2) ? held_q[1] : ((cnt_q == 2'd1) ? data_byte : 8'd0);
		grp.b2     = (cnt_q == 2'd2) ? data_byte : 8'd0;
		grp.nbytes = cnt_q + 2'd1;
		grp.last   = end_of_message;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (acc) begin
			cnt_q <= closes ? 2'd0 : cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !closes) begin
			held_q[cnt_q[0]] <= data_byte;
		end
	end

endmodule

// ----- rtl/core/b64e_gq.sv -----
`timescale 1ns / 1ps
module b64e_gq import b64e_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  group_t wr_grp,
	input  logic   rd,
	output group_t rd_grp,
	output logic   q_full,
	output logic   q_empty
);

	group_t     ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rd_grp  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) wr_ptr_q <= ~wr_ptr_q;
			if (rd) rd_ptr_q <= ~rd_ptr_q;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wr_ptr_q] <= wr_grp;
		end
	end

endmodule

// ----- rtl/core/b64e_back.sv -----
`timescale 1ns / 1ps
module b64e_back import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  group_t     grp,
	input  logic       grp_empty,
	output logic       grp_pop,
	input  logic       pop,
	output logic       empty,
	output logic [6:0] out_char,
	output logic       last_char
);

	group_t     cur_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       oval_q;
	logic [6:0] char_q;
	logic       last_q;
	logic       pop_acc;
	logic       adv;
	logic       done;
	logic [6:0] nxt_char;

	assign pop_acc = pop & oval_q;
	assign adv     = busy_q & (~oval_q | pop_acc);
	assign done    = adv & (idx_q == CHAR_LAST);
	assign grp_pop = ~grp_empty & (~busy_q | done);

	assign empty     = ~oval_q;
	assign out_char  = char_q;
	assign last_char = last_q;

	always_comb begin
		unique case (idx_q)
			2'd0:    nxt_char = b64_char(cur_q.b0[7:2]);
			2'd1:    nxt_char = b64_char({cur_q.b0[1:0], cur_q.b1[7:4]});
			2'd2:    nxt_char = (cur_q.nbytes > 2'd1) ?
				b64_char({cur_q.b1[3:0], cur_q.b2[7:6]}) : PAD_CHAR;
			default: nxt_char = (cur_q.nbytes > 2'd2) ? b64_char(cur_q.b2[5:0]) : PAD_CHAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
			oval_q <= 1'b0;
		end else begin
			if (grp_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (adv) begin
				busy_q <= ~done;
				idx_q  <= idx_q + 2'd1;
			end
			if (adv) oval_q <= 1'b1;
			else if (pop_acc) oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_pop) cur_q <= grp;
		if (adv) begin
			char_q <= nxt_char;
			last_q <= (idx_q == CHAR_LAST) & cur_q.last;
		end
	end

endmodule

// ----- rtl/core/base64_stream_encoder.sv -----
// Path: the closing byte's group is written to the group queue, then to the back's
// group register, then its first character to the output register. Throughput:
// one character word per cycle while each word is popped; four words per group.
// Reset: arst_n asynchronous active low; clears held count, group queue and
// output valid; no clearing pass, the block takes words straight after reset.
`timescale 1ns / 1ps
`include "base64_stream_encoder_assert.svh"
module base64_stream_encoder import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output logic       empty,
	input  logic       pop,
	output logic [6:0] out_char,
	output logic       last_char
);

	// front: collects bytes into groups of up to three
	// queue: two groups deep, lets front and back stall apart
	// back: spells each group out as four characters, one a cycle while popped
	group_t gq_in;
	group_t gq_out;
	logic   gq_push;
	logic   gq_pop;
	logic   gq_full;
	logic   gq_empty;

	b64e_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.grp_full       (gq_full),
		.full           (full),
		.grp_push       (gq_push),
		.grp            (gq_in)
	);

	b64e_gq u_gq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (gq_push),
		.wr_grp  (gq_in),
		.rd      (gq_pop),
		.rd_grp  (gq_out),
		.q_full  (gq_full),
		.q_empty (gq_empty)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (gq_out),
		.grp_empty (gq_empty),
		.grp_pop   (gq_pop),
		.pop       (pop),
		.empty     (empty),
		.out_char  (out_char),
		.last_char (last_char)
	);

	// front never pushes into a full queue, back never pops an empty one
	`B64E_ASSERT_IMP(a_no_overflow, clk, arst_n, gq_push, !gq_full)
	`B64E_ASSERT_IMP(a_no_underflow, clk, arst_n, gq_pop, !gq_empty)
	// every shown word is a printable base64 code
	`B64E_ASSERT_IMP(a_char_range, clk, arst_n, !empty, (out_char >= 7'd43) && (out_char <= 7'd122))
	// a closing group is in the queue by the next cycle
	`B64E_ASSERT_NXT(a_grp_lands, clk, arst_n, gq_push && !gq_pop, !gq_empty)

endmodule
